FILE: rtl/core/bfca_pkg.sv
// Shared constants, types and handshake structs of the best-fit cell allocator.
`timescale 1ns / 1ps

package bfca_pkg;

	localparam int CELLS        = 64;
	localparam int ADDR_W       = $clog2(CELLS);
	localparam int CNT_W        = $clog2(CELLS + 1);
	localparam int REGION_W     = 7;
	localparam int SIZE_W       = 7;
	localparam int TAG_W        = 8;
	localparam int START_W      = 6;
	localparam int FREED_W      = 7;

	localparam logic [REGION_W-1:0] REGION_RESET = 7'd64;
	localparam logic [TAG_W-1:0]    TAG_FIRST    = 8'd1;
	localparam logic [TAG_W-1:0]    TAG_LAST     = 8'd255;

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_FREE    = 2'd1,
		OP_COMPACT = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef struct packed {
		logic load;
		logic issue;
		logic close;
		logic fill;
		logic clear;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		op_t  op;
		logic skip;
		logic last_issue;
		logic found;
		logic fill_last;
		logic clear_done;
	} dp_stat_t;

endpackage

FILE: rtl/core/bfca_cell_ram.sv
// Cell owner memory: one write port, one registered read port, per-entry valid bits.
`timescale 1ns / 1ps

module bfca_cell_ram (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [bfca_pkg::ADDR_W-1:0] rd_addr,
	output logic [bfca_pkg::TAG_W-1:0]  rd_data,
	input  logic                        wr_en,
	input  logic [bfca_pkg::ADDR_W-1:0] wr_addr,
	input  logic [bfca_pkg::TAG_W-1:0]  wr_data
);

	logic [bfca_pkg::TAG_W-1:0] mem [bfca_pkg::CELLS];
	logic [bfca_pkg::CELLS-1:0] valid_q;
	logic [bfca_pkg::TAG_W-1:0] data_q;
	logic                       vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_q   <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				vld_q <= valid_q[rd_addr];
			end
		end
	end

	// never-written cells read as free
	assign rd_data = vld_q ? data_q : '0;

endmodule

FILE: rtl/core/bfca_datapath.sv
// Datapath: region register, scan pipeline, best-run tracking, write selection, results.
`timescale 1ns / 1ps

module bfca_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bfca_pkg::ctrl_cmd_t           cmd,
	output bfca_pkg::dp_stat_t            stat,
	input  logic [1:0]                    opcode,
	input  logic [bfca_pkg::SIZE_W-1:0]   request_size,
	input  logic [bfca_pkg::TAG_W-1:0]    free_tag,
	input  logic                          cfg_we,
	input  logic [bfca_pkg::REGION_W-1:0] cfg_data,
	output logic                          result_valid,
	output logic                          status,
	output logic [bfca_pkg::START_W-1:0]  start_cell,
	output logic [bfca_pkg::TAG_W-1:0]    granted_tag,
	output logic [bfca_pkg::FREED_W-1:0]  cells_freed
);

	logic [bfca_pkg::REGION_W-1:0] region_q;
	logic [bfca_pkg::CNT_W-1:0]    n_in;
	logic [bfca_pkg::CNT_W-1:0]    n_q;
	bfca_pkg::op_t                 op_in;
	bfca_pkg::op_t                 op_q;
	logic [bfca_pkg::SIZE_W-1:0]   want_q;
	logic [bfca_pkg::TAG_W-1:0]    tag_in_q;
	logic [bfca_pkg::TAG_W-1:0]    next_tag_q;

	logic [bfca_pkg::CNT_W-1:0]    idx_q;
	logic                          rv_s1;
	logic [bfca_pkg::CNT_W-1:0]    ridx_s1;
	logic [bfca_pkg::TAG_W-1:0]    rd_data;

	logic                          in_run_q;
	logic [bfca_pkg::CNT_W-1:0]    run_start_q;
	logic                          found_q;
	logic [bfca_pkg::CNT_W-1:0]    best_start_q;
	logic [bfca_pkg::CNT_W-1:0]    best_len_q;
	logic [bfca_pkg::CNT_W-1:0]    count_q;
	logic [bfca_pkg::CNT_W-1:0]    w_q;
	logic [bfca_pkg::CNT_W-1:0]    fill_q;

	logic                          cell_free;
	logic                          run_end;
	logic [bfca_pkg::CNT_W-1:0]    end_idx;
	logic [bfca_pkg::CNT_W-1:0]    cand_len;
	logic                          better;

	logic                          wr_en;
	logic [bfca_pkg::ADDR_W-1:0]   wr_addr;
	logic [bfca_pkg::TAG_W-1:0]    wr_data;
	logic                          alloc_ok;

	bfca_cell_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (cmd.issue),
		.rd_addr (idx_q[bfca_pkg::ADDR_W-1:0]),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	always_comb begin
		if (32'(region_q) > 32'(bfca_pkg::CELLS)) begin
			n_in = bfca_pkg::CNT_W'(bfca_pkg::CELLS);
		end else begin
			n_in = bfca_pkg::CNT_W'(region_q);
		end
	end

	assign op_in = bfca_pkg::op_t'(opcode);

	// run bookkeeping: a run closes on an owned cell or at the region end
	always_comb begin
		cell_free = (rd_data == '0);
		end_idx   = cmd.close ? n_q : ridx_s1;
		cand_len  = end_idx - run_start_q;
		run_end   = in_run_q && ((rv_s1 && !cell_free && op_q == bfca_pkg::OP_ALLOC)
			|| cmd.close);
		better    = run_end && (32'(cand_len) >= 32'(want_q))
			&& (!found_q || cand_len < best_len_q);
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		if (rv_s1 && op_q == bfca_pkg::OP_FREE && rd_data == tag_in_q) begin
			wr_en   = 1'b1;
			wr_addr = ridx_s1[bfca_pkg::ADDR_W-1:0];
		end else if (rv_s1 && op_q == bfca_pkg::OP_COMPACT && !cell_free) begin
			wr_en   = 1'b1;
			wr_addr = w_q[bfca_pkg::ADDR_W-1:0];
			wr_data = rd_data;
		end else if (cmd.clear) begin
			wr_en   = 1'b1;
			wr_addr = w_q[bfca_pkg::ADDR_W-1:0];
		end else if (cmd.fill) begin
			wr_en   = 1'b1;
			wr_addr = bfca_pkg::ADDR_W'(best_start_q + fill_q);
			wr_data = next_tag_q;
		end
	end

	assign alloc_ok = (op_q == bfca_pkg::OP_ALLOC) && found_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_q     <= bfca_pkg::REGION_RESET;
			next_tag_q   <= bfca_pkg::TAG_FIRST;
			op_q         <= bfca_pkg::OP_NONE;
			want_q       <= '0;
			tag_in_q     <= '0;
			n_q          <= '0;
			rv_s1        <= 1'b0;
			ridx_s1      <= '0;
			in_run_q     <= 1'b0;
			run_start_q  <= '0;
			found_q      <= 1'b0;
			best_start_q <= '0;
			best_len_q   <= '0;
			idx_q        <= '0;
			count_q      <= '0;
			w_q          <= '0;
			fill_q       <= '0;
			result_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				region_q <= cfg_data;
			end
			rv_s1   <= cmd.issue;
			ridx_s1 <= idx_q;
			result_valid <= cmd.finish;

			if (cmd.load) begin
				op_q     <= op_in;
				want_q   <= request_size;
				tag_in_q <= free_tag;
				n_q      <= n_in;
				idx_q    <= '0;
				in_run_q <= 1'b0;
				found_q  <= 1'b0;
				count_q  <= '0;
				w_q      <= '0;
				fill_q   <= '0;
			end

			if (cmd.issue) begin
				idx_q <= idx_q + 1'b1;
			end

			if (rv_s1 && op_q == bfca_pkg::OP_ALLOC) begin
				if (cell_free && !in_run_q) begin
					in_run_q    <= 1'b1;
					run_start_q <= ridx_s1;
				end else if (!cell_free && in_run_q) begin
					in_run_q <= 1'b0;
				end
			end
			if (cmd.close) begin
				in_run_q <= 1'b0;
			end
			if (better) begin
				found_q      <= 1'b1;
				best_start_q <= run_start_q;
				best_len_q   <= cand_len;
			end

			if (rv_s1 && op_q == bfca_pkg::OP_FREE && rd_data == tag_in_q) begin
				count_q <= count_q + 1'b1;
			end
			if ((rv_s1 && op_q == bfca_pkg::OP_COMPACT && !cell_free) || cmd.clear) begin
				w_q <= w_q + 1'b1;
			end
			if (cmd.fill) begin
				fill_q <= fill_q + 1'b1;
			end

			if (cmd.finish && alloc_ok) begin
				next_tag_q <= (next_tag_q == bfca_pkg::TAG_LAST) ? bfca_pkg::TAG_FIRST
					: next_tag_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status      <= (op_q == bfca_pkg::OP_ALLOC) && !found_q;
			start_cell  <= alloc_ok ? bfca_pkg::START_W'(best_start_q) : '0;
			granted_tag <= alloc_ok ? next_tag_q : '0;
			cells_freed <= (op_q == bfca_pkg::OP_FREE) ? bfca_pkg::FREED_W'(count_q) : '0;
		end
	end

	always_comb begin
		stat.op         = op_q;
		stat.skip       = (op_in == bfca_pkg::OP_NONE) || (n_in == '0)
			|| (op_in == bfca_pkg::OP_ALLOC && request_size == '0)
			|| (op_in == bfca_pkg::OP_FREE && free_tag == '0);
		stat.last_issue = (idx_q + 1'b1) == n_q;
		stat.found      = found_q;
		stat.fill_last  = (32'(fill_q) + 32'd1) == 32'(want_q);
		stat.clear_done = (w_q == n_q);
	end

endmodule

FILE: rtl/core/bfca_ctrl.sv
// Controller: sequences scan, run close, fill and clear phases of each operation.
`timescale 1ns / 1ps

module bfca_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  bfca_pkg::dp_stat_t  stat,
	output bfca_pkg::ctrl_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WAIT,
		ST_CLOSE,
		ST_DECIDE,
		ST_FILL,
		ST_CLEAR,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   busy_q;

	always_comb begin
		cmd        = '0;
		cmd.load   = (state_q == ST_IDLE) && start;
		cmd.issue  = (state_q == ST_SCAN);
		cmd.close  = (state_q == ST_CLOSE);
		cmd.fill   = (state_q == ST_FILL);
		cmd.clear  = (state_q == ST_CLEAR) && !stat.clear_done;
		cmd.finish = (state_q == ST_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						busy_q  <= 1'b1;
						state_q <= stat.skip ? ST_DONE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (stat.last_issue) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					case (stat.op)
						bfca_pkg::OP_ALLOC:   state_q <= ST_CLOSE;
						bfca_pkg::OP_COMPACT: state_q <= ST_CLEAR;
						default:              state_q <= ST_DONE;
					endcase
				end
				ST_CLOSE: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					state_q <= stat.found ? ST_FILL : ST_DONE;
				end
				ST_FILL: begin
					if (stat.fill_last) begin
						state_q <= ST_DONE;
					end
				end
				ST_CLEAR: begin
					if (stat.clear_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					busy_q  <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: begin
					busy_q  <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy = busy_q;

endmodule

FILE: rtl/core/best_fit_cell_allocator.sv
// Top level of the best-fit cell allocator.
`timescale 1ns / 1ps

// One operation at a time: start is taken while busy is low and the single result
// appears on the result ports for one cycle, marked by result_valid, which the
// receiver must take as it comes. The cell map is a single-port-read memory
// walked one cell per cycle over n active cells (region_size capped at 64). A
// compact packs owned cells to the front, then clears the rest; an allocate
// closes the last run and fills request_size cells on a grant. Opcode 3, an
// empty region, a zero-size request and a tag-0 free skip the scan. No clearing
// pass follows reset. region_size is written over the cfg channel while idle.
module best_fit_cell_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    opcode,
	input  logic [bfca_pkg::SIZE_W-1:0]   request_size,
	input  logic [bfca_pkg::TAG_W-1:0]    free_tag,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bfca_pkg::REGION_W-1:0] cfg_data,
	output logic                          result_valid,
	output logic                          status,
	output logic [bfca_pkg::START_W-1:0]  start_cell,
	output logic [bfca_pkg::TAG_W-1:0]    granted_tag,
	output logic [bfca_pkg::FREED_W-1:0]  cells_freed
);

	bfca_pkg::ctrl_cmd_t cmd;
	bfca_pkg::dp_stat_t  stat;

	assign cfg_ready = !busy;

	bfca_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	bfca_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.opcode       (opcode),
		.request_size (request_size),
		.free_tag     (free_tag),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.status       (status),
		.start_cell   (start_cell),
		.granted_tag  (granted_tag),
		.cells_freed  (cells_freed)
	);

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accepted transfer");

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe longer than one cycle");

	a_fail_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status |-> start_cell == '0 && granted_tag == '0
			&& cells_freed == '0)
		else $error("failed allocate reports non-zero fields");

	a_grant_no_free: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && granted_tag != '0 |-> !status && cells_freed == '0)
		else $error("grant reported together with freed cells or failure");
`endif

endmodule
